/* hw/rtl/fsc_pkg.sv */
// Shared types, codes and letter helpers for the four-square cipher stream.
package fsc_pkg;

    // Square geometry and alphabet
    localparam int SIDE       = 5;
    localparam int CELLS      = 25;
    localparam int IDX_W      = 5;
    localparam logic [IDX_W-1:0] PAD_IDX = 5'd22;   // index of 'x' (no q)

    // Queue sizes
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_AW     = 2;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_AW     = 2;
    localparam int CNT_W      = 3;

    // Input item kinds
    localparam logic [2:0] KIND_MSG    = 3'd0;
    localparam logic [2:0] KIND_EOM    = 3'd1;
    localparam logic [2:0] KIND_BEGIN  = 3'd2;
    localparam logic [2:0] KIND_KEY1   = 3'd3;
    localparam logic [2:0] KIND_KEY2   = 3'd4;
    localparam logic [2:0] KIND_FINISH = 3'd5;

    // Command codes from front to back
    localparam logic [2:0] OP_PAIR   = 3'd0;
    localparam logic [2:0] OP_EOM    = 3'd1;
    localparam logic [2:0] OP_BEGIN  = 3'd2;
    localparam logic [2:0] OP_KEY1   = 3'd3;
    localparam logic [2:0] OP_KEY2   = 3'd4;
    localparam logic [2:0] OP_FINISH = 3'd5;

    typedef struct packed {
        logic [2:0] item_kind;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_letter;
        logic       letter_valid;
        logic       last_of_message;
        logic       status;
    } t_out_item;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic             last;
        logic             status;
        logic             decrypt;
    } t_cmd;

    typedef struct packed {
        logic fill_busy;
        logic cmd_pop;
    } t_back_stat;

    // Letter index of a lowercase byte other than q; valid flag in the top bit
    function automatic logic [IDX_W:0] letter_index(input logic [7:0] c);
        logic [7:0] d;
        d = c - 8'h61;
        if (c < 8'h61 || c > 8'h7a || c == 8'h71) begin
            return '0;
        end
        if (c < 8'h71) begin
            return {1'b1, d[IDX_W-1:0]};
        end
        return {1'b1, IDX_W'(d - 8'd1)};
    endfunction

    // ASCII letter of an alphabet index
    function automatic logic [7:0] alpha_char(input logic [IDX_W-1:0] idx);
        if (idx < 5'd16) begin
            return 8'h61 + {3'b000, idx};
        end
        return 8'h62 + {3'b000, idx};
    endfunction

    // Row of a square position, by comparison against the row starts
    function automatic logic [2:0] row_of(input logic [IDX_W-1:0] v);
        if (v >= 5'd20) begin
            return 3'd4;
        end
        if (v >= 5'd15) begin
            return 3'd3;
        end
        if (v >= 5'd10) begin
            return 3'd2;
        end
        if (v >= 5'd5) begin
            return 3'd1;
        end
        return 3'd0;
    endfunction

    // Column: position less five times its row
    function automatic logic [2:0] col_of(input logic [IDX_W-1:0] v);
        logic [2:0] r;
        r = row_of(v);
        return 3'(v - {r, 2'b00} - {2'b00, r});
    endfunction

    // Square position from row and column
    function automatic logic [IDX_W-1:0] pos_of(input logic [2:0] r, input logic [2:0] c);
        return IDX_W'({r, 2'b00} + {2'b00, r} + {2'b00, c});
    endfunction

endpackage

/* hw/rtl/fsc_front.sv */
// Front end: cleans and classifies input items, pairs message letters, holds the mode.
module fsc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  fsc_pkg::t_in_item i_item,
    input  logic             i_cfg_we,
    input  logic             i_cfg_data,
    output logic             o_cmd_push,
    output fsc_pkg::t_cmd    o_cmd
);

    logic                        r_decrypt;
    logic                        r_held_valid;
    logic [fsc_pkg::IDX_W-1:0]   r_held_letter;
    logic                        n_held_valid;
    logic [fsc_pkg::IDX_W-1:0]   n_held_letter;
    logic [7:0]                  msg_byte;
    logic [fsc_pkg::IDX_W:0]     msg_li;
    logic [fsc_pkg::IDX_W:0]     key_li;

    // Lowercase message bytes before lookup
    always_comb begin
        msg_byte = i_item.byte_value;
        if (msg_byte >= 8'h41 && msg_byte <= 8'h5a) begin
            msg_byte = msg_byte + 8'h20;
        end
        msg_li = fsc_pkg::letter_index(msg_byte);
        key_li = fsc_pkg::letter_index(i_item.byte_value);
    end

    // Classify the item into a back-end request
    always_comb begin
        o_cmd_push    = 1'b0;
        o_cmd         = '0;
        o_cmd.decrypt = r_decrypt;
        n_held_valid  = r_held_valid;
        n_held_letter = r_held_letter;
        unique case (i_item.item_kind)
            fsc_pkg::KIND_MSG: begin
                if (msg_li[fsc_pkg::IDX_W]) begin
                    if (!r_held_valid) begin
                        n_held_valid  = 1'b1;
                        n_held_letter = msg_li[fsc_pkg::IDX_W-1:0];
                    end else begin
                        n_held_valid = 1'b0;
                        o_cmd_push   = 1'b1;
                        o_cmd.op     = fsc_pkg::OP_PAIR;
                        o_cmd.a      = r_held_letter;
                        o_cmd.b      = msg_li[fsc_pkg::IDX_W-1:0];
                    end
                end
            end
            fsc_pkg::KIND_EOM: begin
                o_cmd_push   = 1'b1;
                n_held_valid = 1'b0;
                if (r_held_valid && !r_decrypt) begin
                    // odd letter padded with x
                    o_cmd.op   = fsc_pkg::OP_PAIR;
                    o_cmd.a    = r_held_letter;
                    o_cmd.b    = fsc_pkg::PAD_IDX;
                    o_cmd.last = 1'b1;
                end else begin
                    o_cmd.op     = fsc_pkg::OP_EOM;
                    o_cmd.status = r_held_valid;
                end
            end
            fsc_pkg::KIND_BEGIN: begin
                o_cmd_push    = 1'b1;
                o_cmd.op      = fsc_pkg::OP_BEGIN;
                n_held_valid  = 1'b0;
                n_held_letter = '0;
            end
            fsc_pkg::KIND_KEY1: begin
                o_cmd_push = key_li[fsc_pkg::IDX_W];
                o_cmd.op   = fsc_pkg::OP_KEY1;
                o_cmd.a    = key_li[fsc_pkg::IDX_W-1:0];
            end
            fsc_pkg::KIND_KEY2: begin
                o_cmd_push = key_li[fsc_pkg::IDX_W];
                o_cmd.op   = fsc_pkg::OP_KEY2;
                o_cmd.a    = key_li[fsc_pkg::IDX_W-1:0];
            end
            fsc_pkg::KIND_FINISH: begin
                o_cmd_push = 1'b1;
                o_cmd.op   = fsc_pkg::OP_FINISH;
            end
            default: begin
                o_cmd_push = 1'b0;
            end
        endcase
        if (!i_accept) begin
            o_cmd_push    = 1'b0;
            n_held_valid  = r_held_valid;
            n_held_letter = r_held_letter;
        end
    end

    // Mode register and held letter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt     <= 1'b0;
            r_held_valid  <= 1'b0;
            r_held_letter <= '0;
        end else begin
            if (i_cfg_we) begin
                r_decrypt <= i_cfg_data;
            end
            r_held_valid  <= n_held_valid;
            r_held_letter <= n_held_letter;
        end
    end

endmodule

/* hw/rtl/fsc_cmd_queue.sv */
// Short request queue between the front and back ends.
module fsc_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fsc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output fsc_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);

    fsc_pkg::t_cmd                 r_q [fsc_pkg::CMD_DEPTH];
    logic [fsc_pkg::CMD_AW-1:0]    r_wp;
    logic [fsc_pkg::CMD_AW-1:0]    r_rp;
    logic [fsc_pkg::CNT_W-1:0]     r_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == fsc_pkg::CNT_W'(fsc_pkg::CMD_DEPTH));
    assign o_head  = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{(fsc_pkg::CNT_W-1){1'b0}}, do_push}
                           - {{(fsc_pkg::CNT_W-1){1'b0}}, do_pop};
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

/* hw/rtl/fsc_back.sv */
// Back end: keyed squares, fill sequencer, pair lookup and the result queue.
module fsc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fsc_pkg::t_cmd         i_head,
    input  logic                  i_q_empty,
    input  logic                  i_pop,
    output fsc_pkg::t_out_item    o_out_item,
    output logic                  o_empty,
    output fsc_pkg::t_back_stat   o_stat
);

    localparam int W = fsc_pkg::IDX_W;

    // Squares and inverse maps
    logic [W-1:0] r_sq1 [fsc_pkg::CELLS];
    logic [W-1:0] r_sq2 [fsc_pkg::CELLS];
    logic [W-1:0] r_wh1 [fsc_pkg::CELLS];
    logic [W-1:0] r_wh2 [fsc_pkg::CELLS];
    logic [fsc_pkg::CELLS-1:0] r_used1;
    logic [fsc_pkg::CELLS-1:0] r_used2;
    logic [W-1:0] r_pre1;
    logic [W-1:0] r_pre2;
    logic         r_fill_busy;
    logic [W-1:0] r_fill_li;

    // Result queue
    fsc_pkg::t_out_item             r_oq [fsc_pkg::OUT_DEPTH];
    logic [fsc_pkg::OUT_AW-1:0]     r_wp;
    logic [fsc_pkg::OUT_AW-1:0]     r_rp;
    logic [fsc_pkg::CNT_W-1:0]      r_cnt;

    logic [1:0]                 need;
    logic [fsc_pkg::CNT_W-1:0]  space;
    logic                       exec;
    logic [W-1:0]               p1;
    logic [W-1:0]               p2;
    logic [W-1:0]               r1_idx;
    logic [W-1:0]               r2_idx;
    logic                       place1_en;
    logic                       place2_en;
    logic [W-1:0]               place1_li;
    logic [W-1:0]               place2_li;
    logic                       do1;
    logic                       do2;
    logic                       clr;
    logic                       fill_start;
    logic                       wr0;
    logic                       wr1;
    logic                       rd;
    fsc_pkg::t_out_item         item0;
    fsc_pkg::t_out_item         item1;

    // Issue decision: a head request, no fill running, and room for every result it writes
    always_comb begin
        case (i_head.op)
            fsc_pkg::OP_PAIR: need = 2'd2;
            fsc_pkg::OP_EOM:  need = 2'd1;
            default:          need = 2'd0;
        endcase
        space = fsc_pkg::CNT_W'(fsc_pkg::OUT_DEPTH) - r_cnt;
        exec  = !i_q_empty && !r_fill_busy && ({1'b0, need} <= space);
    end

    // Pair lookup: square cells when encrypting, positions when decrypting
    always_comb begin
        if (i_head.decrypt) begin
            p1     = r_wh1[i_head.a];
            p2     = r_wh2[i_head.b];
            r1_idx = fsc_pkg::pos_of(fsc_pkg::row_of(p1), fsc_pkg::col_of(p2));
            r2_idx = fsc_pkg::pos_of(fsc_pkg::row_of(p2), fsc_pkg::col_of(p1));
        end else begin
            p1     = fsc_pkg::pos_of(fsc_pkg::row_of(i_head.a), fsc_pkg::col_of(i_head.b));
            p2     = fsc_pkg::pos_of(fsc_pkg::row_of(i_head.b), fsc_pkg::col_of(i_head.a));
            r1_idx = r_sq1[p1];
            r2_idx = r_sq2[p2];
        end
    end

    // Results written by the head request
    always_comb begin
        item0 = '0;
        item1 = '0;
        if (i_head.op == fsc_pkg::OP_PAIR) begin
            item0.out_letter   = fsc_pkg::alpha_char(r1_idx);
            item0.letter_valid = 1'b1;
        end else begin
            item0.last_of_message = 1'b1;
            item0.status          = i_head.status;
        end
        item1.out_letter      = fsc_pkg::alpha_char(r2_idx);
        item1.letter_valid    = 1'b1;
        item1.last_of_message = i_head.last;
        wr0 = exec && (i_head.op == fsc_pkg::OP_PAIR || i_head.op == fsc_pkg::OP_EOM);
        wr1 = exec && (i_head.op == fsc_pkg::OP_PAIR);
        rd  = i_pop && !o_empty;
    end

    // Letter placement from key bytes or the fill sweep
    always_comb begin
        place1_en  = r_fill_busy || (exec && i_head.op == fsc_pkg::OP_KEY1);
        place2_en  = r_fill_busy || (exec && i_head.op == fsc_pkg::OP_KEY2);
        place1_li  = r_fill_busy ? r_fill_li : i_head.a;
        place2_li  = r_fill_busy ? r_fill_li : i_head.a;
        do1        = place1_en && !r_used1[place1_li] && (r_pre1 < W'(fsc_pkg::CELLS));
        do2        = place2_en && !r_used2[place2_li] && (r_pre2 < W'(fsc_pkg::CELLS));
        clr        = exec && (i_head.op == fsc_pkg::OP_BEGIN);
        fill_start = exec && (i_head.op == fsc_pkg::OP_FINISH);
    end

    // Square contents, reset to plain order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fsc_pkg::CELLS; i++) begin
                r_sq1[i] <= W'(i);
                r_sq2[i] <= W'(i);
                r_wh1[i] <= W'(i);
                r_wh2[i] <= W'(i);
            end
        end else begin
            if (do1) begin
                r_sq1[r_pre1]     <= place1_li;
                r_wh1[place1_li]  <= r_pre1;
            end
            if (do2) begin
                r_sq2[r_pre2]     <= place2_li;
                r_wh2[place2_li]  <= r_pre2;
            end
        end
    end

    // Key state and fill sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used1     <= '0;
            r_used2     <= '0;
            r_pre1      <= '0;
            r_pre2      <= '0;
            r_fill_busy <= 1'b0;
            r_fill_li   <= '0;
        end else begin
            if (clr) begin
                r_used1 <= '0;
                r_used2 <= '0;
                r_pre1  <= '0;
                r_pre2  <= '0;
            end
            if (do1) begin
                r_used1[place1_li] <= 1'b1;
                r_pre1             <= r_pre1 + 1'b1;
            end
            if (do2) begin
                r_used2[place2_li] <= 1'b1;
                r_pre2             <= r_pre2 + 1'b1;
            end
            if (fill_start) begin
                r_fill_busy <= 1'b1;
                r_fill_li   <= '0;
            end else if (r_fill_busy) begin
                r_fill_li <= r_fill_li + 1'b1;
                if (r_fill_li == W'(fsc_pkg::CELLS - 1)) begin
                    r_fill_busy <= 1'b0;
                end
            end
        end
    end

    // Result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + fsc_pkg::OUT_AW'({wr1, wr0 && !wr1});
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{(fsc_pkg::CNT_W-1){1'b0}}, wr0}
                           + {{(fsc_pkg::CNT_W-1){1'b0}}, wr1}
                           - {{(fsc_pkg::CNT_W-1){1'b0}}, rd};
        end
    end

    // Result queue entries
    always_ff @(posedge i_clk) begin
        if (wr0) begin
            r_oq[r_wp] <= item0;
        end
        if (wr1) begin
            r_oq[r_wp + 1'b1] <= item1;
        end
    end

    assign o_out_item       = r_oq[r_rp];
    assign o_empty          = (r_cnt == '0);
    assign o_stat.fill_busy = r_fill_busy;
    assign o_stat.cmd_pop   = exec;

endmodule

/* hw/rtl/four_square_cipher_stream.sv */
// Top level of the four-square cipher stream: front end, request queue, back end.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+---------------------------
//  input    | in        | push / full      | i_in_item  (kind, byte)
//  result   | out       | empty / pop      | o_out_item (letter, flags)
//  config   | in        | i_cfg_we         | i_cfg_data (decrypt mode)
//
// One request is taken per cycle while the request queue has room; a message
// pair is queued, then issues and leaves two results once no fill runs and both fit.
// Finish keys holds the back end: it issues, then sweeps 25 fill letters into the squares.
// Reset is synchronous; both squares return to plain order at once.
// Stalls on the result side back up through the result and request queues.
module four_square_cipher_stream (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  fsc_pkg::t_in_item   i_in_item,
    output logic                empty,
    input  logic                pop,
    output fsc_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data
);

    logic                 cmd_push;
    fsc_pkg::t_cmd        cmd;
    fsc_pkg::t_cmd        head;
    logic                 q_empty;
    fsc_pkg::t_back_stat  stat;

    fsc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !full),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd)
    );

    fsc_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd),
        .i_pop   (stat.cmd_pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (full)
    );

    fsc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_empty  (q_empty),
        .i_pop      (pop),
        .o_out_item (o_out_item),
        .o_empty    (empty),
        .o_stat     (stat)
    );

`ifndef SYNTHESIS
    // No request leaves the queue while the fill sweep runs
    a_no_issue_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.fill_busy |-> !stat.cmd_pop)
        else $error("request issued during square fill");

    // A result without a letter always closes a message
    a_blank_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.letter_valid) |->
            (o_out_item.last_of_message && o_out_item.out_letter == 8'h00))
        else $error("blank result not marked last");

    // The dropped-letter flag only rides on a blank closing result
    a_status_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.status) |->
            (!o_out_item.letter_valid && o_out_item.last_of_message))
        else $error("status flag on a letter result");
`endif

endmodule

/* verif/fsc_stream_checker.sv */
`timescale 1ns / 100ps
// Checker for the four-square cipher stream: predicts results per request and compares them.
module fsc_stream_checker
    import fsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_item  i_in_item,
    input  logic      i_empty,
    input  logic      i_pop,
    input  t_out_item i_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    output int        o_mismatches,
    output int        o_outstanding
);

    localparam int         NO_LETTER = -1;
    localparam logic [7:0] PAD_CHAR  = "x";

    // Predicted block state: index 0 is the first square, 1 the second
    logic [IDX_W-1:0] square   [2][CELLS];
    logic [IDX_W-1:0] where_at [2][CELLS];
    logic [CELLS-1:0] placed   [2];
    int               filled   [2];
    logic [IDX_W-1:0] held_idx;
    logic             held_ok;
    logic             decrypting;
    t_out_item        expected_letters [$];

    // Alphabet index of a lowercase letter other than q
    function automatic int letter_idx(input logic [7:0] c);
        if (c < "a" || c > "z" || c == "q") return NO_LETTER;
        return (c < "q") ? int'(c - "a") : int'(c - "a") - 1;
    endfunction

    // ASCII of an alphabet index; q is skipped
    function automatic logic [7:0] letter_char(input int idx);
        return (idx < 16) ? 8'(8'h61 + idx) : 8'(8'h62 + idx);
    endfunction

    task automatic clear_state();
        int s;
        int l;
        for (s = 0; s < 2; s++) begin
            for (l = 0; l < CELLS; l++) begin
                square[s][l]   = IDX_W'(l);
                where_at[s][l] = IDX_W'(l);
            end
            placed[s] = '0;
            filled[s] = 0;
        end
        held_idx   = '0;
        held_ok    = 1'b0;
        decrypting = 1'b0;
        expected_letters.delete();
    endtask

    // Key letter goes to the next free position unless already in that square or the square is full
    task automatic place_key(input int sq, input int li);
        if (placed[sq][li] || filled[sq] >= CELLS) return;
        square[sq][filled[sq]] = IDX_W'(li);
        where_at[sq][li]       = IDX_W'(filled[sq]);
        placed[sq][li]         = 1'b1;
        filled[sq]++;
    endtask

    // Two letters of a pair in the current mode
    task automatic expect_pair(input int a, input int b, input logic last);
        int        p1;
        int        p2;
        t_out_item r1;
        t_out_item r2;
        r1 = '0;
        r2 = '0;
        if (decrypting) begin
            p1 = where_at[0][a];
            p2 = where_at[1][b];
            r1.out_letter = letter_char((p1 / SIDE) * SIDE + p2 % SIDE);
            r2.out_letter = letter_char((p2 / SIDE) * SIDE + p1 % SIDE);
        end else begin
            r1.out_letter = letter_char(square[0][(a / SIDE) * SIDE + b % SIDE]);
            r2.out_letter = letter_char(square[1][(b / SIDE) * SIDE + a % SIDE]);
        end
        r1.letter_valid    = 1'b1;
        r2.letter_valid    = 1'b1;
        r2.last_of_message = last;
        expected_letters.insert(expected_letters.size(), r1);
        expected_letters.insert(expected_letters.size(), r2);
    endtask

    // Effect of one accepted request
    task automatic cipher_step(input t_in_item req);
        logic [7:0] c;
        int         li;
        int         s;
        int         l;
        t_out_item  tail;
        c    = req.byte_value;
        tail = '0;
        case (req.item_kind)
            KIND_MSG: begin
                if (c >= "A" && c <= "Z") c = c + 8'h20;
                li = letter_idx(c);
                if (li != NO_LETTER) begin
                    if (!held_ok) begin
                        held_idx = IDX_W'(li);
                        held_ok  = 1'b1;
                    end else begin
                        held_ok = 1'b0;
                        expect_pair(held_idx, li, 1'b0);
                    end
                end
            end
            KIND_EOM: begin
                // odd letter: padded when encrypting, dropped and flagged when decrypting
                if (held_ok && !decrypting) begin
                    expect_pair(held_idx, letter_idx(PAD_CHAR), 1'b1);
                end else begin
                    tail.last_of_message = 1'b1;
                    tail.status          = held_ok;
                    expected_letters.insert(expected_letters.size(), tail);
                end
                held_ok = 1'b0;
            end
            KIND_BEGIN: begin
                // squares keep their contents until overwritten
                placed[0] = '0;
                placed[1] = '0;
                filled[0] = 0;
                filled[1] = 0;
                held_idx  = '0;
                held_ok   = 1'b0;
            end
            KIND_KEY1, KIND_KEY2: begin
                li = letter_idx(c);
                if (li != NO_LETTER) place_key(req.item_kind == KIND_KEY2, li);
            end
            KIND_FINISH: begin
                for (s = 0; s < 2; s++) begin
                    for (l = 0; l < CELLS; l++) place_key(s, l);
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            o_mismatches++;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_letters.size() == 0) begin
            $error("result with no request behind it: out_letter %h", got.out_letter);
            o_mismatches++;
            return;
        end
        want = expected_letters.pop_front();
        compare_field("out_letter", want.out_letter, got.out_letter);
        compare_field("letter_valid", 8'(want.letter_valid), 8'(got.letter_valid));
        compare_field("last_of_message", 8'(want.last_of_message), 8'(got.last_of_message));
        compare_field("status", 8'(want.status), 8'(got.status));
    endtask

    // Sample all channels at the rising edge; a request sees the mode held before the edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            o_mismatches = 0;
        end else begin
            if (i_pop && !i_empty) check_result(i_out_item);
            if (i_push && !i_full) cipher_step(i_in_item);
            if (i_cfg_we) decrypting = i_cfg_data;
        end
        o_outstanding = expected_letters.size();
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Testbench top: drives requests, result pops and mode writes, and reports the verdict.
module tb;
    import fsc_pkg::*;

    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam logic       MODE_ENCRYPT  = 1'b0;
    localparam logic       MODE_DECRYPT  = 1'b1;
    localparam int         RANDOM_ITEMS  = 1200;
    localparam int         MAX_GAP       = 17;
    localparam int         SETTLE_CYCLES = 128;
    localparam int         CYCLE_LIMIT   = 600000;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    logic      empty;
    logic      pop;
    logic      cfg_we;
    logic      cfg_data;
    t_in_item  in_item;
    t_out_item out_item;
    int        mismatches;
    int        outstanding;
    int        cycle_count = 0;
    int        sent;
    logic      calm = 1'b0;

    four_square_cipher_stream dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    fsc_stream_checker u_cipher_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_in_item     (in_item),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_out_item    (out_item),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Idle cycles before a request; none during calm stretches
    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [7:0] msg_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 8'($urandom_range(8'h61, 8'h7a));
        if (r < 8) return 8'($urandom_range(8'h41, 8'h5a));
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] key_char();
        return ($urandom_range(0, 7) != 0) ? 8'($urandom_range(8'h61, 8'h7a))
                                          : 8'($urandom);
    endfunction

    // Result side: random stall per result, then pop until taken
    initial begin
        int stall;
        pop = 1'b0;
        wait (rst_n);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                pop = 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop = 1'b1;
            do @(posedge clk); while (empty);
            @(negedge clk);
        end
    end

    // One request; push stays high if the next follows without a gap
    task automatic send(input logic [2:0] kind, input logic [7:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item.item_kind  = kind;
        in_item.byte_value = val;
        push = 1'b1;
        do @(posedge clk); while (full);
        @(negedge clk);
        if (kind <= KIND_FINISH) sent++;
    endtask

    // Hold off until every result is in, then let queued work drain
    task automatic settle();
        push = 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        settle();
        cfg_data = mode;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    task automatic run_key_setup();
        int n;
        if ($urandom_range(0, 9) != 0) send(KIND_BEGIN, 8'($urandom));
        n = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 12);
        repeat (n) send($urandom_range(0, 1) ? KIND_KEY2 : KIND_KEY1, key_char());
        if ($urandom_range(0, 6) != 0) send(KIND_FINISH, 8'($urandom));
    endtask

    task automatic run_message();
        repeat ($urandom_range(0, 14)) send(KIND_MSG, msg_char());
        send(KIND_EOM, 8'($urandom));
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 6)) send(3'($urandom_range(0, 7)), 8'($urandom));
    endtask

    initial begin
        int pick;
        rst_n    = 1'b0;
        push     = 1'b0;
        in_item  = '0;
        cfg_we   = 1'b0;
        cfg_data = MODE_ENCRYPT;
        sent     = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: plain squares, case folding, dropped bytes, padding
        write_mode(MODE_ENCRYPT);
        send(KIND_MSG, "A");
        send(KIND_MSG, "z");
        send(KIND_MSG, "q");
        send(KIND_MSG, 8'h00);
        send(KIND_MSG, 8'hff);
        send(KIND_MSG, "Q");
        send(KIND_EOM, 8'h00);
        send(KIND_MSG, "m");
        send(KIND_EOM, 8'hff);
        send(KIND_SPARE_LO, "a");
        send(KIND_SPARE_HI, "z");
        // duplicate, upper-case and q key bytes ignored; message on half-built squares
        send(KIND_BEGIN, 8'h00);
        send(KIND_KEY1, "z");
        send(KIND_KEY1, "z");
        send(KIND_KEY1, "Q");
        send(KIND_KEY1, "q");
        send(KIND_KEY2, 8'hff);
        send(KIND_KEY2, "a");
        send(KIND_MSG, "b");
        send(KIND_MSG, "c");
        send(KIND_FINISH, 8'h00);
        // begin keys drops a held letter
        send(KIND_MSG, "k");
        send(KIND_BEGIN, 8'h00);
        send(KIND_KEY1, "k");
        send(KIND_FINISH, 8'h00);
        send(KIND_EOM, 8'h00);
        // decrypt with an odd trailing letter; finish again without begin
        write_mode(MODE_DECRYPT);
        send(KIND_MSG, "y");
        send(KIND_MSG, "x");
        send(KIND_MSG, "e");
        send(KIND_EOM, 8'h00);
        send(KIND_FINISH, 8'h00);
        send(KIND_EOM, 8'h00);

        // Random phases, mode rewritten between them
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            write_mode(1'($urandom_range(0, 1)));
            calm = ($urandom_range(0, 3) == 0);
            repeat (8) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) run_key_setup();
                else if (pick < 85) run_message();
                else run_noise();
            end
        end

        calm = 1'b0;
        settle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_front.sv
hw/rtl/fsc_cmd_queue.sv
hw/rtl/fsc_back.sv
hw/rtl/four_square_cipher_stream.sv
verif/fsc_stream_checker.sv
verif/tb.sv
